// File: sv/imm_pkg.sv
// Shared types and codes for the integer matrix multiply unit.
package imm_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_ROW     = 2'd2
    } imm_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } imm_state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } imm_ctl_t;

    localparam int unsigned DATA_W = 32;

endpackage

// File: sv/imm_cell.sv
// One column cell: holds a column of B, multiplies the passing A stream, accumulates.
module imm_cell
    import imm_pkg::*;
#(
    parameter int SIDE  = 16,
    parameter int IDX_W = 4,
    parameter int COL   = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                b_we,
    input  logic [IDX_W-1:0]    b_addr,
    input  logic [IDX_W-1:0]    b_col,
    input  logic [DATA_W-1:0]   b_data,
    input  imm_ctl_t            ctl_in,
    input  logic [IDX_W-1:0]    k_in,
    input  logic [DATA_W-1:0]   a_in,
    output imm_ctl_t            ctl_out,
    output logic [IDX_W-1:0]    k_out,
    output logic [DATA_W-1:0]   a_out,
    input  logic                shift,
    input  logic [DATA_W-1:0]   res_in,
    output logic [DATA_W-1:0]   res_out,
    output logic                done
);

    logic [DATA_W-1:0] bmem [SIDE];
    logic [DATA_W-1:0] b_rd_reg;

    imm_ctl_t           ctl1_reg;
    imm_ctl_t           ctl2_reg;
    logic               done_reg;
    logic [IDX_W-1:0]   k1_reg;
    logic [DATA_W-1:0]  a1_reg;
    logic [DATA_W-1:0]  p_reg;
    logic [DATA_W-1:0]  acc_reg;
    logic [DATA_W-1:0]  acc_next;
    logic [DATA_W-1:0]  res_reg;
    logic [DATA_W-1:0]  res_next;
    logic [2*DATA_W-1:0] full_prod;

    always_ff @(posedge clk)
    begin
        if (b_we && (b_col == IDX_W'(COL)))
        begin
            bmem[b_addr] <= b_data;
        end
        b_rd_reg <= bmem[k_in];
    end

    assign full_prod = a1_reg * b_rd_reg;

    always_comb
    begin
        acc_next = ctl2_reg.first ? p_reg : (acc_reg + p_reg);
        if (ctl2_reg.valid && ctl2_reg.last)
        begin
            res_next = acc_next;
        end
        else if (shift)
        begin
            res_next = res_in;
        end
        else
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg  <= k_in;
        a1_reg  <= a_in;
        p_reg   <= full_prod[DATA_W-1:0];
        res_reg <= res_next;
        if (ctl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign ctl_out = ctl1_reg;
    assign k_out   = k1_reg;
    assign a_out   = a1_reg;
    assign res_out = res_reg;
    assign done    = done_reg;

endmodule

// File: sv/integer_matrix_multiply_unit.sv
// Top level: A store, row sequencer, chain of column cells and result output.
//
// Slave stream takes words: tuser = opcode, tdata = row, column, element.
// Opcode write A / write B stores one element. Out-of-range
// indexes and the unused opcode are dropped. Opcode row starts a product row:
// the A row streams through a chain of SIDE column cells, one element per
// cycle, each cell multiplying by its stored B column and accumulating.
// After the row word is accepted, the chain drains and the SIDE result
// words are presented in column order, one per cycle while the
// receiver is ready, tlast on the final one. The slave side takes a word
// only when the unit is idle. When the receiver stalls, the result chain
// holds and the current word stays on the master port. Reset clears control
// state only; matrix contents are undefined until written.
module integer_matrix_multiply_unit
    import imm_pkg::*;
#(
    parameter int SIDE = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index[3:0], col_index[7:4], element_value[39:8]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row[3:0], out_col[7:4], product_value[39:8]
    output logic        m_axis_tlast    // last_of_row
);

    localparam int IDX_W = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int AW    = $clog2(SIDE * SIDE);

    logic [3:0]         in_row;
    logic [3:0]         in_col;
    logic [DATA_W-1:0]  in_value;
    logic               in_fire;
    logic               row_ok;
    logic               col_ok;

    imm_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   kcnt_reg, kcnt_next;
    logic [AW-1:0]      a_addr_reg, a_addr_next;
    logic [3:0]         row_reg, row_next;
    logic [IDX_W-1:0]   emit_reg, emit_next;
    imm_ctl_t           feed_ctl_reg, feed_ctl_next;
    logic [IDX_W-1:0]   feed_k_reg;

    logic [DATA_W-1:0]  amem [SIDE*SIDE];
    logic [DATA_W-1:0]  a_rd_reg;
    logic               a_we;
    logic               b_we;
    logic               shift;

    imm_ctl_t           ctl_link [SIDE+1];
    logic [IDX_W-1:0]   k_link   [SIDE+1];
    logic [DATA_W-1:0]  a_link   [SIDE+1];
    logic [DATA_W-1:0]  res_link [SIDE+1];
    logic [SIDE-1:0]    cell_done;
    logic               chain_done;

    assign in_row   = s_axis_tdata[3:0];
    assign in_col   = s_axis_tdata[7:4];
    assign in_value = s_axis_tdata[39:8];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign row_ok   = 32'(in_row) < 32'(SIDE);
    assign col_ok   = 32'(in_col) < 32'(SIDE);

    assign a_we  = in_fire && (s_axis_tuser == OP_WRITE_A) && row_ok && col_ok;
    assign b_we  = in_fire && (s_axis_tuser == OP_WRITE_B) && row_ok && col_ok;
    assign shift = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            amem[AW'(32'(in_row) * SIDE + 32'(in_col))] <= in_value;
        end
        a_rd_reg   <= amem[a_addr_reg];
        feed_k_reg <= kcnt_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        kcnt_next     = kcnt_reg;
        a_addr_next   = a_addr_reg;
        row_next      = row_reg;
        emit_next     = emit_reg;
        feed_ctl_next = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_fire && (s_axis_tuser == OP_ROW) && row_ok)
                begin
                    state_next  = ST_FEED;
                    kcnt_next   = '0;
                    a_addr_next = AW'(32'(in_row) * SIDE);
                    row_next    = in_row;
                end
            end
            ST_FEED:
            begin
                feed_ctl_next.valid = 1'b1;
                feed_ctl_next.first = (kcnt_reg == '0);
                feed_ctl_next.last  = (kcnt_reg == IDX_W'(SIDE - 1));
                kcnt_next   = kcnt_reg + 1'b1;
                a_addr_next = a_addr_reg + 1'b1;
                if (kcnt_reg == IDX_W'(SIDE - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (chain_done)
                begin
                    state_next = ST_EMIT;
                    emit_next  = '0;
                end
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (emit_reg == IDX_W'(SIDE - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kcnt_reg     <= '0;
            a_addr_reg   <= '0;
            row_reg      <= '0;
            emit_reg     <= '0;
            feed_ctl_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            kcnt_reg     <= kcnt_next;
            a_addr_reg   <= a_addr_next;
            row_reg      <= row_next;
            emit_reg     <= emit_next;
            feed_ctl_reg <= feed_ctl_next;
        end
    end

    assign ctl_link[0]    = feed_ctl_reg;
    assign k_link[0]      = feed_k_reg;
    assign a_link[0]      = a_rd_reg;
    assign res_link[SIDE] = '0;

    for (genvar j = 0; j < SIDE; j++)
    begin : g_cell
        imm_cell #(
            .SIDE  (SIDE),
            .IDX_W (IDX_W),
            .COL   (j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .b_we    (b_we),
            .b_addr  (IDX_W'(in_row)),
            .b_col   (IDX_W'(in_col)),
            .b_data  (in_value),
            .ctl_in  (ctl_link[j]),
            .k_in    (k_link[j]),
            .a_in    (a_link[j]),
            .ctl_out (ctl_link[j+1]),
            .k_out   (k_link[j+1]),
            .a_out   (a_link[j+1]),
            .shift   (shift),
            .res_in  (res_link[j+1]),
            .res_out (res_link[j]),
            .done    (cell_done[j])
        );
    end

    assign chain_done = cell_done[SIDE-1] && (ctl_link[SIDE].valid == 1'b0);

    assign m_axis_tdata = {res_link[0], 4'(emit_reg), row_reg};
    assign m_axis_tlast = (emit_reg == IDX_W'(SIDE - 1));

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input taken while results pending");

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cell_done[SIDE-1] |-> (state_reg == ST_DRAIN))
        else $error("chain completion outside drain");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("unit not idle after last word of row");

    a_feed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (feed_ctl_reg.valid && feed_ctl_reg.first) |-> $past(state_reg) == ST_FEED)
        else $error("feed started outside sequencer run");
`endif

endmodule

// File: test/tb_integer_matrix_multiply_unit.sv
// Testbench for integer_matrix_multiply_unit: element writes, row products, scoreboard checks.
module tb_integer_matrix_multiply_unit
    import imm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 3 * SIDE + 5;
    localparam int RANDOM_ITEMS = 160;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        last;
    } product_word_t;

    // Mirror of both matrix stores plus the queue of product words still owed.
    class product_scoreboard;
        logic [31:0]   a_store [SIDE*SIDE];
        logic [31:0]   b_store [SIDE*SIDE];
        product_word_t owed_q [$];
        int            failures;
        int            matched;

        function new();
            failures = 0;
            matched  = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_word(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                                logic [31:0] value);
            logic [31:0]   acc;
            product_word_t w;
            unique case (op)
                OP_WRITE_A:
                    if (row < SIDE && col < SIDE) a_store[row*SIDE + col] = value;
                OP_WRITE_B:
                    if (row < SIDE && col < SIDE) b_store[row*SIDE + col] = value;
                OP_ROW:
                    if (row < SIDE)
                    begin
                        for (int c = 0; c < SIDE; c++)
                        begin
                            acc = 32'd0;
                            for (int k = 0; k < SIDE; k++)
                                acc = acc + a_store[row*SIDE + k] * b_store[k*SIDE + c];
                            w.row   = row;
                            w.col   = c[3:0];
                            w.value = acc;
                            w.last  = (c == SIDE - 1);
                            owed_q.push_back(w);
                        end
                    end
                default: ;
            endcase
        endfunction

        function void check_word(logic [39:0] data, logic last);
            product_word_t exp_w;
            if (owed_q.size() == 0)
            begin
                $error("unexpected product word %h last %b", data, last);
                failures++;
                return;
            end
            exp_w = owed_q.pop_front();
            if (data[3:0] !== exp_w.row)
            begin
                $error("out_row expected %0d actual %0d", exp_w.row, data[3:0]);
                failures++;
            end
            if (data[7:4] !== exp_w.col)
            begin
                $error("out_col expected %0d actual %0d", exp_w.col, data[7:4]);
                failures++;
            end
            if (data[39:8] !== exp_w.value)
            begin
                $error("product_value expected %h actual %h", exp_w.value, data[39:8]);
                failures++;
            end
            if (last !== exp_w.last)
            begin
                $error("last_of_row expected %b actual %b", exp_w.last, last);
                failures++;
            end
            matched++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    product_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left = 0;
    int n_writes = 0;
    int n_rows = 0;
    int n_ignored = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int stall_left = 0;

    integer_matrix_multiply_unit #(.SIDE(SIDE)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_integer_matrix_multiply_unit failed");
            $finish;
        end
    end

    // Receiver: checks accepted words, stalls in modes that change every so often.
    always @(posedge clk)
    begin
        logic ready_next;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast);
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(50, 300);
            end
            else
            begin
                rx_mode_left--;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                unique case (rx_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = 1'($urandom_range(0, 1));
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            stall_left = $urandom_range(1, 20);
                            ready_next = 1'b0;
                        end
                        else
                        begin
                            ready_next = 1'b1;
                        end
                    end
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    function automatic logic [31:0] rand_element();
        unique case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                             logic [31:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {value, col, row};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_word(op, row, col, value);
        unique case (op)
            OP_WRITE_A, OP_WRITE_B: n_writes++;
            OP_ROW: n_rows++;
            default: n_ignored++;
        endcase
    endtask

    // Sender burst/gap pattern, applied before each word.
    task automatic sender_slot();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic paced_word(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                              logic [31:0] value);
        sender_slot();
        send_word(op, row, col, value);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored opcode before anything is stored
        paced_word(OP_UNUSED, 4'd0, 4'd0, 32'hffff_ffff);

        // fill both stores so every later row product reads written elements
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
            begin
                paced_word(OP_WRITE_B, r[3:0], c[3:0], rand_element());
                paced_word(OP_WRITE_A, r[3:0], c[3:0], rand_element());
            end

        // directed: extreme elements, corner rows, ignored opcode over stored data
        paced_word(OP_WRITE_A, 4'd0,  4'd0,  32'h8000_0000);
        paced_word(OP_WRITE_B, 4'd0,  4'd0,  32'h8000_0000);
        paced_word(OP_WRITE_A, 4'd0,  4'd15, 32'h7fff_ffff);
        paced_word(OP_WRITE_B, 4'd15, 4'd15, 32'h7fff_ffff);
        paced_word(OP_WRITE_A, 4'd15, 4'd0,  32'hffff_ffff);
        paced_word(OP_WRITE_B, 4'd0,  4'd15, 32'hffff_ffff);
        paced_word(OP_WRITE_A, 4'd15, 4'd15, 32'h0000_0000);
        paced_word(OP_WRITE_B, 4'd15, 4'd0,  32'h0000_0001);
        paced_word(OP_ROW,     4'd0,  4'd15, 32'hffff_ffff);
        paced_word(OP_ROW,     4'd15, 4'd0,  32'h0000_0000);
        paced_word(OP_UNUSED,  4'd15, 4'd15, 32'h5a5a_a5a5);
        paced_word(OP_UNUSED,  4'd0,  4'd0,  32'ha5a5_5a5a);
        paced_word(OP_ROW,     4'd15, 4'd15, 32'h1234_5678);
        paced_word(OP_ROW,     4'd0,  4'd0,  32'h0000_0000);
        wait_all_results();

        // random: short write runs followed by a row product, some ignored words
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_all_results();
            pick = $urandom_range(0, 19);
            if (pick < 14)
                paced_word(pick[0] ? OP_WRITE_A : OP_WRITE_B, 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), rand_element());
            else if (pick < 19)
                paced_word(OP_ROW, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           $urandom());
            else
                paced_word(OP_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           $urandom());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d element writes, %0d row products, %0d ignored words,",
                 n_writes, n_rows, n_ignored);
        $display("%0d product words checked, random sender bursts and receiver stalls.",
                 sb.matched);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_integer_matrix_multiply_unit passed");
        else
            $display("tb_integer_matrix_multiply_unit failed");
        $finish;
    end

endmodule
